@@ design/ffsa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants for the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int HEADER_BYTES  = 32;
    localparam int ADDR_BITS     = 32;
    localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
    localparam int CFG_BITS      = 32;
    localparam int MIN_BITS      = 25;

    localparam logic [MIN_BITS-1:0]  GROW_MIN_RST    = MIN_BITS'(12288);
    localparam logic [MIN_BITS-1:0]  RELEASE_MIN_RST = MIN_BITS'(4096);
    localparam logic [31:0]          HEAP_LIMIT_RST  = 32'd16777216;

    localparam logic [1:0] REG_GROW_MIN    = 2'd0;
    localparam logic [1:0] REG_RELEASE_MIN = 2'd1;
    localparam logic [1:0] REG_HEAP_LIMIT  = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_HEAP_LIMIT = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;

    typedef struct packed {
        logic        opcode;
        logic [31:0] request_bytes;
        logic [31:0] payload_address;
    } t_in_item;

    typedef struct packed {
        logic [31:0] granted_address;
        logic [31:0] granted_bytes;
        logic [1:0]  status;
        logic [31:0] heap_top;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [31:0]          payload;
    } t_seg;

    // chain command, same for every cell in a cycle
    typedef enum logic [1:0] {
        CC_HOLD,
        CC_SHL,   // cell i takes cell i+1 (remove at or above position)
        CC_SHR    // cell i takes cell i-1 (open a hole at position)
    } t_chain_op;

    typedef struct packed {
        t_chain_op            op;
        logic [CNT_BITS-1:0]  pos;    // cells at or beyond pos move
        logic                 wr;     // overwrite cell at wr_pos
        logic [CNT_BITS-1:0]  wr_pos;
        t_seg                 wr_seg;
    } t_chain_ctl;

endpackage
`default_nettype wire

@@ design/ffsa_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_cell
// One slot of the free-segment table; shifts to or from its neighbors.
// ----------------------------------------------------------------------------
module ffsa_cell (
    input  wire logic                    i_clk,
    input  wire logic [ffsa_pkg::CNT_BITS-1:0] i_index,
    input  wire ffsa_pkg::t_chain_ctl    i_ctl,
    input  wire ffsa_pkg::t_seg          i_from_left,
    input  wire ffsa_pkg::t_seg          i_from_right,
    output ffsa_pkg::t_seg               o_seg
);
    import ffsa_pkg::*;

    t_seg r_seg;
    t_seg n_seg;

    always_comb begin
        n_seg = r_seg;
        if (i_index >= i_ctl.pos) begin
            unique case (i_ctl.op)
                CC_SHL:  n_seg = i_from_right;
                CC_SHR:  if (i_index != i_ctl.pos) n_seg = i_from_left;
                default: n_seg = r_seg;
            endcase
        end
        if (i_ctl.wr && i_ctl.wr_pos == i_index) n_seg = i_ctl.wr_seg;
    end

    always_ff @(posedge i_clk) begin
        r_seg <= n_seg;
    end

    assign o_seg = r_seg;

endmodule
`default_nettype wire

@@ design/ffsa_chain.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffsa_chain
// Row of table cells; the entry at the read position and the one after it are presented to the sequencer.
// ----------------------------------------------------------------------------
module ffsa_chain (
    input  wire logic                          i_clk,
    input  wire ffsa_pkg::t_chain_ctl          i_ctl,
    input  wire logic [ffsa_pkg::CNT_BITS-1:0] i_rd_pos,
    output ffsa_pkg::t_seg                     o_rd_a,
    output ffsa_pkg::t_seg                     o_rd_b
);
    import ffsa_pkg::*;

    t_seg w_seg [TABLE_ENTRIES+1];
    localparam int IDX_BITS = $clog2(TABLE_ENTRIES);

    assign w_seg[TABLE_ENTRIES] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        ffsa_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (CNT_BITS'(g)),
            .i_ctl        (i_ctl),
            .i_from_left  ((g == 0) ? w_seg[0] : w_seg[(g == 0) ? 0 : g-1]),
            .i_from_right (w_seg[g+1]),
            .o_seg        (w_seg[g])
        );
    end

    // entry at rd_pos and the one after it
    always_comb begin
        o_rd_a = '0;
        o_rd_b = '0;
        if (i_rd_pos < CNT_BITS'(TABLE_ENTRIES)) o_rd_a = w_seg[i_rd_pos[IDX_BITS-1:0]];
        if (i_rd_pos + 1'b1 < CNT_BITS'(TABLE_ENTRIES))
            o_rd_b = w_seg[IDX_BITS'(i_rd_pos + 1'b1)];
    end

endmodule
`default_nettype wire

@@ design/first_fit_segment_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit heap allocator over an address-sorted free-segment table.
// ----------------------------------------------------------------------------
// Each transaction (alloc or free) is processed alone and returns one result.
// The free table is a row of cells that shifts one place per cycle; the
// sequencer walks it one entry per cycle. An alloc is served from the table
// if an entry fits; otherwise it grows the top (or hits the heap limit),
// with a second scan for the insert point when the leftover is recorded. A
// free locates and inserts its segment and, if it was inserted, makes a
// merge pass over the table and does the release check; a free below one
// header goes straight to the result. Count, the table entries, is at most
// 16. The input stalls while a transaction is in flight or its result is
// still held, so the next request is taken in the cycle after the result
// is accepted.
module first_fit_segment_allocator (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output      logic                    o_in_stall,
    input  wire ffsa_pkg::t_in_item      i_in_data,
    output      logic                    o_out_valid,
    input  wire logic                    i_out_stall,
    output      ffsa_pkg::t_out_item     o_out_data,
    input  wire logic                    i_cfg_we,
    input  wire logic [1:0]              i_cfg_index,
    input  wire logic [31:0]             i_cfg_data
);
    import ffsa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_AFIND, S_GROW, S_GINS, S_FINS, S_MERGE, S_REL, S_DONE
    } t_state;

    t_state               r_state;
    logic [MIN_BITS-1:0]  r_grow_min, r_rel_min;
    logic [31:0]          r_limit;
    logic [CNT_BITS-1:0]  r_count, r_pos;
    logic [31:0]          r_top;
    t_in_item             r_req;
    t_seg                 r_ins;       // pending insert for grow leftover / free
    logic [31:0]          r_gbytes_alt;
    t_out_item            r_out;
    logic                 r_out_valid;
    t_chain_ctl           w_ctl;
    t_seg                 w_a, w_b;

    ffsa_chain u_chain (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_rd_pos (r_pos),
        .o_rd_a   (w_a),
        .o_rd_b   (w_b)
    );

    localparam logic [32:0] HDR = 33'(HEADER_BYTES);

    logic [32:0] w_rem;      // payload - request
    logic [32:0] w_g;        // grow payload
    logic [33:0] w_new_top;
    logic [33:0] w_merge;
    logic [32:0] w_end_a;

    assign w_rem      = {1'b0, w_a.payload} - {1'b0, r_req.request_bytes};
    assign w_g        = (r_req.request_bytes > 32'(r_grow_min)) ? {1'b0, r_req.request_bytes}
                                                                : 33'(r_grow_min);
    assign w_new_top  = {2'b0, r_top} + {1'b0, w_g} + 34'(HEADER_BYTES);
    assign w_merge    = {2'b0, w_a.payload} + 34'(HEADER_BYTES) + {2'b0, w_b.payload};
    assign w_end_a    = {1'b0, w_a.start} + HDR + {1'b0, w_a.payload};

    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // insert search: first pos whose start >= ins.start
    logic w_ins_here;
    assign w_ins_here = (r_pos >= r_count) || (w_a.start >= r_ins.start);

    always_comb begin
        w_ctl = '{op: CC_HOLD, pos: '0, wr: 1'b0, wr_pos: '0, wr_seg: '0};
        unique case (r_state)
            S_AFIND: begin
                if (r_pos < r_count && w_a.payload >= r_req.request_bytes) begin
                    if (w_rem > HDR) begin
                        w_ctl.wr = 1'b1;
                        w_ctl.wr_pos = r_pos;
                        w_ctl.wr_seg.start = w_a.start + 32'(HEADER_BYTES)
                                             + r_req.request_bytes;
                        w_ctl.wr_seg.payload = 32'(w_rem - HDR);
                    end else begin
                        w_ctl.op = CC_SHL;
                        w_ctl.pos = r_pos;
                    end
                end
            end
            S_GINS, S_FINS: begin
                if (w_ins_here && !(r_pos < r_count && w_a.start == r_ins.start)
                    && r_count < CNT_BITS'(TABLE_ENTRIES)) begin
                    w_ctl.op = CC_SHR;
                    w_ctl.pos = r_pos;
                    w_ctl.wr = 1'b1;
                    w_ctl.wr_pos = r_pos;
                    w_ctl.wr_seg = r_ins;
                end
            end
            S_MERGE: begin
                if (r_pos + 1'b1 < r_count && w_end_a == {1'b0, w_b.start}) begin
                    w_ctl.op = CC_SHL;
                    w_ctl.pos = r_pos + 1'b1;
                    w_ctl.wr = 1'b1;
                    w_ctl.wr_pos = r_pos;
                    w_ctl.wr_seg.start = w_a.start;
                    w_ctl.wr_seg.payload = w_merge[33:32] != 2'b0 ? 32'hFFFF_FFFF
                                                                   : w_merge[31:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grow_min  <= GROW_MIN_RST;
            r_rel_min   <= RELEASE_MIN_RST;
            r_limit     <= HEAP_LIMIT_RST;
            r_count     <= '0;
            r_top       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_GROW_MIN:    r_grow_min <= i_cfg_data[MIN_BITS-1:0];
                    REG_RELEASE_MIN: r_rel_min  <= i_cfg_data[MIN_BITS-1:0];
                    REG_HEAP_LIMIT:  r_limit    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_req <= i_in_data;
                        r_pos <= '0;
                        r_out <= '0;
                        r_ins.start   <= i_in_data.payload_address - 32'(HEADER_BYTES);
                        r_ins.payload <= i_in_data.request_bytes;
                        if (i_in_data.opcode == OP_ALLOC) r_state <= S_AFIND;
                        else if (i_in_data.payload_address >= 32'(HEADER_BYTES))
                            r_state <= S_FINS;
                        else r_state <= S_DONE;
                    end
                end
                S_AFIND: begin
                    if (r_pos >= r_count) begin
                        r_state <= S_GROW;
                    end else if (w_a.payload >= r_req.request_bytes) begin
                        r_out.granted_address <= w_a.start + 32'(HEADER_BYTES);
                        if (w_rem > HDR) begin
                            r_out.granted_bytes <= r_req.request_bytes;
                        end else begin
                            r_out.granted_bytes <= w_a.payload;
                            r_count <= r_count - 1'b1;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_GROW: begin
                    if (w_new_top[33:32] != 2'b0 || w_new_top[31:0] > r_limit) begin
                        r_out.status <= ST_HEAP_LIMIT;
                        r_state <= S_DONE;
                    end else begin
                        r_top <= w_new_top[31:0];
                        r_out.granted_address <= r_top + 32'(HEADER_BYTES);
                        r_gbytes_alt <= w_g[31:0];
                        if (w_g - {1'b0, r_req.request_bytes} > HDR) begin
                            r_ins.start <= r_top + 32'(HEADER_BYTES) + r_req.request_bytes;
                            r_ins.payload <= 32'(w_g - {1'b0, r_req.request_bytes} - HDR);
                            r_pos <= '0;
                            r_state <= S_GINS;
                        end else begin
                            r_out.granted_bytes <= w_g[31:0];
                            r_state <= S_DONE;
                        end
                    end
                end
                S_GINS, S_FINS: begin
                    if (r_pos < r_count && w_a.start == r_ins.start) begin
                        if (r_state == S_GINS) r_out.granted_bytes <= r_gbytes_alt;
                        r_state <= S_DONE;
                    end else if (w_ins_here) begin
                        if (r_count >= CNT_BITS'(TABLE_ENTRIES)) begin
                            r_out.status <= ST_TABLE_FULL;
                            if (r_state == S_GINS) r_out.granted_bytes <= r_gbytes_alt;
                            r_state <= S_DONE;
                        end else begin
                            r_count <= r_count + 1'b1;
                            if (r_state == S_GINS) begin
                                r_out.granted_bytes <= r_req.request_bytes;
                                r_state <= S_DONE;
                            end else begin
                                r_pos <= '0;
                                r_state <= S_MERGE;
                            end
                        end
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_MERGE: begin
                    if (r_pos + 1'b1 >= r_count) begin
                        r_pos <= (r_count == '0) ? '0 : r_count - 1'b1;
                        r_state <= S_REL;
                    end else if (w_end_a == {1'b0, w_b.start}) begin
                        r_count <= r_count - 1'b1;
                    end else begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                S_REL: begin
                    if (r_count != '0 && w_end_a == {1'b0, r_top}
                        && w_a.payload >= 32'(r_rel_min)) begin
                        r_top <= w_a.start;
                        r_count <= r_count - 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out.heap_top <= r_top;
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit segment allocator.
// ----------------------------------------------------------------------------
// A directed table covers reset, overrun, table full, ignored frees and zero
// requests; random phases then mix well-formed alloc/free traffic with noise
// under several register settings. Every result is compared with an internal
// heap model.
// ----------------------------------------------------------------------------
module tb_top;
    import ffsa_pkg::*;

    localparam int ENTRIES = 16;
    localparam int HDR     = 32;
    localparam int IDLE_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1600;
    localparam logic [1:0] REG_NONE = 2'd3;   // unmapped index, write is dropped

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_item   o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    first_fit_segment_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // heap model state
    logic [31:0] free_start [ENTRIES];
    logic [31:0] free_bytes [ENTRIES];
    int          free_count;
    logic [31:0] heap_top;
    logic [24:0] grow_min;
    logic [24:0] release_min;
    logic [31:0] limit_addr;

    t_out_item   expected_q[$];
    logic [31:0] live_addr[$];
    logic [31:0] live_bytes[$];
    int          errors;
    int          idle_cycles;
    bit          hold_off;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void drop_seg(input int i);
        for (int k = i; k < free_count - 1; k++) begin
            free_start[k] = free_start[k+1];
            free_bytes[k] = free_bytes[k+1];
        end
        free_count--;
    endfunction

    // 0 inserted, 1 duplicate, 2 full
    function automatic int insert_seg(input logic [31:0] s, input logic [31:0] p);
        int i;
        i = 0;
        while (i < free_count && free_start[i] < s) i++;
        if (i < free_count && free_start[i] == s) return 1;
        if (free_count >= ENTRIES) return 2;
        for (int k = free_count; k > i; k--) begin
            free_start[k] = free_start[k-1];
            free_bytes[k] = free_bytes[k-1];
        end
        free_start[i] = s;
        free_bytes[i] = p;
        free_count++;
        return 0;
    endfunction

    function automatic logic [32:0] seg_end(input int i);
        return {1'b0, free_start[i]} + 33'(HDR) + {1'b0, free_bytes[i]};
    endfunction

    function automatic t_out_item predict_heap(input t_in_item it);
        t_out_item r;
        logic [32:0] m, g;
        logic [33:0] newtop;
        int i, rc;
        logic [31:0] s, p, n;
        r = '0;
        n = it.request_bytes;
        if (it.opcode == OP_ALLOC) begin
            i = 0;
            while (i < free_count && free_bytes[i] < n) i++;
            if (i < free_count) begin
                s = free_start[i];
                p = free_bytes[i];
                if (p - n > HDR) begin
                    free_start[i] = s + HDR + n;
                    free_bytes[i] = p - n - HDR;
                    r.granted_bytes = n;
                end else begin
                    drop_seg(i);
                    r.granted_bytes = p;
                end
                r.granted_address = s + HDR;
            end else begin
                g = (n > 32'(grow_min)) ? {1'b0, n} : 33'(grow_min);
                newtop = {2'b0, heap_top} + {1'b0, g} + 34'(HDR);
                if (newtop[33:32] != 2'b0 || newtop[31:0] > limit_addr) begin
                    r.status = ST_HEAP_LIMIT;
                end else begin
                    s = heap_top;
                    heap_top = newtop[31:0];
                    r.granted_address = s + HDR;
                    if (g[31:0] - n > HDR) begin
                        rc = insert_seg(s + HDR + n, g[31:0] - n - HDR);
                        if (rc == 0) r.granted_bytes = n;
                        else begin
                            r.granted_bytes = g[31:0];
                            if (rc == 2) r.status = ST_TABLE_FULL;
                        end
                    end else begin
                        r.granted_bytes = g[31:0];
                    end
                end
            end
        end else if (it.payload_address >= HDR) begin
            rc = insert_seg(it.payload_address - HDR, n);
            if (rc == 2) r.status = ST_TABLE_FULL;
            if (rc == 0) begin
                i = 0;
                while (i + 1 < free_count) begin
                    if (seg_end(i) == {1'b0, free_start[i+1]}) begin
                        m = {1'b0, free_bytes[i]} + 33'(HDR) + {1'b0, free_bytes[i+1]};
                        free_bytes[i] = m[32] ? 32'hFFFF_FFFF : m[31:0];
                        drop_seg(i + 1);
                    end else begin
                        i++;
                    end
                end
                if (free_count > 0 && seg_end(free_count-1) == {1'b0, heap_top}
                    && free_bytes[free_count-1] >= 32'(release_min)) begin
                    heap_top = free_start[free_count-1];
                    drop_seg(free_count - 1);
                end
            end
        end
        r.heap_top = heap_top;
        return r;
    endfunction

    task automatic send_request(input t_in_item it);
        t_out_item r;
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (o_in_stall);
        r = predict_heap(it);
        expected_q.push_back(r);
        if (it.opcode == OP_ALLOC && r.granted_bytes != 0) begin
            live_addr.push_back(r.granted_address);
            live_bytes.push_back(r.granted_bytes);
        end
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        while (expected_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_GROW_MIN:    grow_min    = val[24:0];
            REG_RELEASE_MIN: release_min = val[24:0];
            REG_HEAP_LIMIT:  limit_addr  = val;
            default: ;
        endcase
    endtask

    function automatic t_in_item mk(input logic op, input logic [31:0] n,
                                    input logic [31:0] a);
        t_in_item it;
        it.opcode = op;
        it.request_bytes = n;
        it.payload_address = a;
        return it;
    endfunction

    // random request: mostly frees of live blocks and modest allocs
    task automatic random_request(input int big_pct);
        int pick, k;
        logic [31:0] n;
        pick = $urandom_range(99);
        if (pick < 45 && live_addr.size() != 0) begin
            k = $urandom_range(live_addr.size() - 1);
            send_request(mk(OP_FREE, live_bytes[k], live_addr[k]));
            live_addr.delete(k);
            live_bytes.delete(k);
        end else if (pick < 90) begin
            if ($urandom_range(99) < big_pct) n = $urandom;
            else n = $urandom_range(6000);
            send_request(mk(OP_ALLOC, n, $urandom));
        end else begin
            // noise: bogus, low or repeated frees
            send_request(mk(OP_FREE, $urandom, ($urandom_range(1)) ?
                            32'($urandom_range(HDR)) : $urandom));
        end
        if ($urandom_range(7) == 0) repeat ($urandom_range(6)) @(negedge i_clk);
    endtask

    // receiver stall pattern, with one long hold-off
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (400) @(negedge i_clk);
                hold_off = 1'b0;
                i_out_stall <= 1'b0;
            end else if ($urandom_range(3) == 0) begin
                i_out_stall <= ($urandom_range(2) == 0);
            end
        end
    end

    // checker and watchdog
    always @(posedge i_clk) begin
        t_out_item w;
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", o_out_data.heap_top, 32'h0);
                end else begin
                    w = expected_q.pop_front();
                    if (o_out_data.granted_address !== w.granted_address)
                        report_mismatch("granted_address", o_out_data.granted_address,
                                        w.granted_address);
                    if (o_out_data.granted_bytes !== w.granted_bytes)
                        report_mismatch("granted_bytes", o_out_data.granted_bytes,
                                        w.granted_bytes);
                    if (o_out_data.status !== w.status)
                        report_mismatch("status", 32'(o_out_data.status), 32'(w.status));
                    if (o_out_data.heap_top !== w.heap_top)
                        report_mismatch("heap_top", o_out_data.heap_top, w.heap_top);
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // directed rows: request plus typed-in result where obvious
    typedef struct {
        t_in_item  req;
        bit        known;
        t_out_item res;
    } t_row;

    initial begin
        t_row rows[$];
        t_out_item w;
        t_out_item got;
        int burst;
        errors = 0;
        hold_off = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_GROW_MIN;
        i_cfg_data = '0;
        free_count = 0;
        heap_top = '0;
        grow_min = GROW_MIN_RST;
        release_min = RELEASE_MIN_RST;
        limit_addr = HEAP_LIMIT_RST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // free on empty heap, null and low frees are ignored
        rows.push_back('{mk(OP_FREE, 32'd100, 32'd0), 1'b1, '{0, 0, ST_OK, 0}});
        rows.push_back('{mk(OP_FREE, 32'hFFFF_FFFF, 32'd31), 1'b1, '{0, 0, ST_OK, 0}});
        // request beyond limit
        rows.push_back('{mk(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1,
                         '{0, 0, ST_HEAP_LIMIT, 0}});
        // zero request grows by grow minimum
        rows.push_back('{mk(OP_ALLOC, 32'd0, 32'd0), 1'b1,
                         '{32, 0, ST_OK, 32'd12320}});
        rows.push_back('{mk(OP_ALLOC, 32'd100, 32'd0), 1'b0, '0});
        rows.push_back('{mk(OP_ALLOC, 32'd16777216, 32'd0), 1'b0, '0});
        rows.push_back('{mk(OP_FREE, 32'd0, 32'd32), 1'b0, '0});
        rows.push_back('{mk(OP_FREE, 32'd0, 32'd32), 1'b0, '0});    // double free
        rows.push_back('{mk(OP_ALLOC, 32'd12000, 32'd0), 1'b0, '0});
        rows.push_back('{mk(OP_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFF0), 1'b0, '0});
        for (int k = 0; k < 20; k++)
            rows.push_back('{mk(OP_ALLOC, 32'd40, 32'd0), 1'b0, '0});
        foreach (rows[k]) begin
            w = predict_heap(rows[k].req);
            expected_q.push_back(w);
            if (rows[k].known && w != rows[k].res) begin
                got = w;
                report_mismatch("directed row", got.heap_top, rows[k].res.heap_top);
            end
            i_in_valid = 1'b1;
            i_in_data  = rows[k].req;
            do @(posedge i_clk); while (o_in_stall);
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        settle();

        // tiny table pressure: fragment with small grow minimum, many frees
        write_reg(REG_GROW_MIN, 32'd0);
        write_reg(REG_RELEASE_MIN, 32'h1FF_FFFF);
        write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
        write_reg(REG_NONE, 32'd5);
        for (int k = 0; k < 40; k++) send_request(mk(OP_ALLOC, 32'd8, 32'd0));
        for (int k = live_addr.size() - 2; k >= 0; k -= 2) begin
            send_request(mk(OP_FREE, live_bytes[k], live_addr[k]));
            live_addr.delete(k);
            live_bytes.delete(k);
        end
        // long receiver hold-off while sender keeps offering
        hold_off = 1'b1;
        for (int k = 0; k < 30; k++) random_request(5);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_GROW_MIN, 32'(GROW_MIN_RST));
                    write_reg(REG_RELEASE_MIN, 32'(RELEASE_MIN_RST));
                    write_reg(REG_HEAP_LIMIT, HEAP_LIMIT_RST);
                end
                1: begin
                    write_reg(REG_GROW_MIN, 32'h1FF_FFFF);
                    write_reg(REG_RELEASE_MIN, 32'd0);
                end
                2: begin
                    write_reg(REG_GROW_MIN, 32'd64);
                    write_reg(REG_HEAP_LIMIT, heap_top + 32'd40000);
                end
                default: begin
                    write_reg(REG_GROW_MIN, $urandom_range(20000));
                    write_reg(REG_RELEASE_MIN, $urandom_range(8000));
                    write_reg(REG_HEAP_LIMIT, 32'hFFFF_FFFF);
                end
            endcase
            for (int k = 0; k < RANDOM_ITEMS / 4; ) begin
                burst = $urandom_range(1, 30);
                for (int b = 0; b < burst && k < RANDOM_ITEMS / 4; b++, k++)
                    random_request(phase == 3 ? 20 : 3);
                repeat ($urandom_range(20)) @(negedge i_clk);
                if ($urandom_range(9) == 0) settle();
            end
            settle();
        end

        if (errors == 0 && expected_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
